/* rtl/ael_pkg.sv */
package ael_pkg;

  localparam int LABEL_DEPTH_DEF = 63;
  localparam logic [7:0] DOT_CHAR = 8'd46;
  localparam logic [7:0] MAX_LEN_RESET = 8'd100;
  localparam int PC_W = 4;

  // Jump conditions evaluated by the sequencer
  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NO_REQ,
    C_EOS,
    C_SKIP,
    C_NOT_DOT,
    C_IDX_DONE,
    C_NOT_ERR
  } cond_t;

  // Datapath operations
  typedef enum logic [3:0] {
    A_NONE,
    A_LATCH,
    A_CHK_FULL,
    A_CLR_FINAL,
    A_PUT_LEN,
    A_READ,
    A_PUT_DATA,
    A_FINISH,
    A_STORE,
    A_SET_FINAL,
    A_PUT_ERR
  } act_t;

  typedef struct packed {
    logic             take;    // step accepts a request
    logic             stall;   // step waits for a free output slot
    cond_t            cond;
    logic [PC_W-1:0]  target;
    act_t             act;
  } uword_t;

  typedef struct packed {
    logic eos;
    logic skip;
    logic not_dot;
    logic idx_done;
    logic not_err;
    logic out_free;
  } status_t;

  // Program steps
  localparam logic [PC_W-1:0] P_WAIT     = 4'd0;
  localparam logic [PC_W-1:0] P_EMIT     = 4'd4;
  localparam logic [PC_W-1:0] P_READ     = 4'd5;
  localparam logic [PC_W-1:0] P_FIN      = 4'd7;
  localparam logic [PC_W-1:0] P_STORE    = 4'd8;
  localparam logic [PC_W-1:0] P_END      = 4'd9;
  localparam logic [PC_W-1:0] P_END_ERR  = 4'd10;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '{take: 1'b0, stall: 1'b0, cond: C_ALWAYS, target: P_WAIT, act: A_NONE};
    case (pc)
      4'd0:  w = '{1'b1, 1'b0, C_NO_REQ,   P_WAIT,    A_LATCH};
      4'd1:  w = '{1'b0, 1'b0, C_EOS,      P_END,     A_NONE};
      4'd2:  w = '{1'b0, 1'b0, C_SKIP,     P_WAIT,    A_CHK_FULL};
      4'd3:  w = '{1'b0, 1'b0, C_NOT_DOT,  P_STORE,   A_CLR_FINAL};
      4'd4:  w = '{1'b0, 1'b1, C_NEVER,    P_WAIT,    A_PUT_LEN};
      4'd5:  w = '{1'b0, 1'b0, C_IDX_DONE, P_FIN,     A_READ};
      4'd6:  w = '{1'b0, 1'b1, C_ALWAYS,   P_READ,    A_PUT_DATA};
      4'd7:  w = '{1'b0, 1'b0, C_ALWAYS,   P_WAIT,    A_FINISH};
      4'd8:  w = '{1'b0, 1'b0, C_ALWAYS,   P_WAIT,    A_STORE};
      4'd9:  w = '{1'b0, 1'b0, C_NOT_ERR,  P_EMIT,    A_SET_FINAL};
      4'd10: w = '{1'b0, 1'b1, C_ALWAYS,   P_FIN,     A_PUT_ERR};
      default: w = '{1'b0, 1'b0, C_ALWAYS, P_WAIT,    A_NONE};
    endcase
    return w;
  endfunction

endpackage

/* rtl/apn_label_encoder.sv */
// Channel   Direction  Handshake               Payload
// input     in         in_valid / in_ready     character, end_of_string
// output    out        out_valid / out_ready   out_byte, run_end, string_end, error,
//                                              total_length
// config    in         cfg_we                  cfg_wdata (max_encoded_length)
//
// A microcode step counter runs one step per cycle unless an output step holds;
// requests are taken at step 0. A character is latched, checked and stored. A dot
// emits the run length, then each buffered byte by a read step and an output step.
// End of string does so for the final run or emits an error; a drop exits at step 2.
// Output steps hold while the output register is full and out_ready is low.
// Synchronous reset clears the step counter and string state; the maximum becomes 100.
module apn_label_encoder #(
  parameter int LABEL_DEPTH = ael_pkg::LABEL_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] character,
  input  logic       end_of_string,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       run_end,
  output logic       string_end,
  output logic       error,
  output logic [7:0] total_length
);

  ael_pkg::status_t status;
  ael_pkg::act_t    act;

  ael_sequencer u_seq (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .act      (act),
    .in_ready (in_ready)
  );

  ael_datapath #(
    .LABEL_DEPTH (LABEL_DEPTH)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .act           (act),
    .in_valid      (in_valid),
    .character     (character),
    .end_of_string (end_of_string),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .out_ready     (out_ready),
    .status        (status),
    .out_valid     (out_valid),
    .out_byte      (out_byte),
    .run_end       (run_end),
    .string_end    (string_end),
    .error         (error),
    .total_length  (total_length)
  );

  a_end_closes_run: assert property (@(posedge clk) disable iff (rst)
    out_valid && string_end |-> run_end)
    else $error("string end without run end");

  a_error_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && error |-> string_end && out_byte == 8'd0 && total_length == 8'd0)
    else $error("malformed error result");

  a_length_only_at_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !string_end |-> total_length == 8'd0)
    else $error("total length outside string end");

endmodule

/* rtl/ael_sequencer.sv */
module ael_sequencer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  ael_pkg::status_t   status,
  output ael_pkg::act_t      act,
  output logic               in_ready
);

  logic [ael_pkg::PC_W-1:0] pc;
  logic [ael_pkg::PC_W-1:0] pc_next;
  ael_pkg::uword_t          word;
  logic                     hold;
  logic                     jump;

  assign word = ael_pkg::ucode(pc);
  assign hold = word.stall && !status.out_free;

  always_comb begin
    case (word.cond)
      ael_pkg::C_NEVER:    jump = 1'b0;
      ael_pkg::C_ALWAYS:   jump = 1'b1;
      ael_pkg::C_NO_REQ:   jump = !in_valid;
      ael_pkg::C_EOS:      jump = status.eos;
      ael_pkg::C_SKIP:     jump = status.skip;
      ael_pkg::C_NOT_DOT:  jump = status.not_dot;
      ael_pkg::C_IDX_DONE: jump = status.idx_done;
      ael_pkg::C_NOT_ERR:  jump = status.not_err;
      default:             jump = 1'b0;
    endcase
  end

  always_comb begin
    if (hold) begin
      pc_next = pc;
    end else if (jump) begin
      pc_next = word.target;
    end else begin
      pc_next = pc + 1'b1;
    end
  end

  // Drop the operation while the step waits on the output slot
  assign act = hold ? ael_pkg::A_NONE : word.act;
  assign in_ready = word.take;

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= ael_pkg::P_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

/* rtl/ael_datapath.sv */
module ael_datapath #(
  parameter int LABEL_DEPTH = ael_pkg::LABEL_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  ael_pkg::act_t     act,
  input  logic              in_valid,
  input  logic [7:0]        character,
  input  logic              end_of_string,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  input  logic              out_ready,
  output ael_pkg::status_t  status,
  output logic              out_valid,
  output logic [7:0]        out_byte,
  output logic              run_end,
  output logic              string_end,
  output logic              error,
  output logic [7:0]        total_length
);

  localparam int CW = $clog2(LABEL_DEPTH + 1);
  localparam int AW = (LABEL_DEPTH > 1) ? $clog2(LABEL_DEPTH) : 1;

  logic [7:0]    label_store [LABEL_DEPTH];
  logic [7:0]    max_len;
  logic [CW-1:0] label_count;
  logic [CW-1:0] idx;
  logic [7:0]    running_length;
  logic          overflow_flag;
  logic          final_run;
  logic [7:0]    char_q;
  logic          eos_q;
  logic [7:0]    rdata;
  logic          full;
  logic          label_full;
  logic          idx_last;
  logic          load;

  assign full       = (max_len == 8'd0) || (running_length >= max_len);
  assign label_full = (label_count >= CW'(LABEL_DEPTH));
  assign idx_last   = (idx == label_count);
  assign load       = (act == ael_pkg::A_PUT_LEN) || (act == ael_pkg::A_PUT_DATA) ||
                      (act == ael_pkg::A_PUT_ERR);

  assign status.eos      = eos_q;
  assign status.skip     = overflow_flag || full;
  assign status.not_dot  = (char_q != ael_pkg::DOT_CHAR);
  assign status.idx_done = idx_last;
  assign status.not_err  = !overflow_flag && (max_len != 8'd0);
  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_len        <= ael_pkg::MAX_LEN_RESET;
      label_count    <= '0;
      idx            <= '0;
      running_length <= 8'd1;
      overflow_flag  <= 1'b0;
      final_run      <= 1'b0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_len <= cfg_wdata;
      end
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (act)
        ael_pkg::A_CHK_FULL: begin
          if (full) begin
            overflow_flag <= 1'b1;
          end
        end
        ael_pkg::A_CLR_FINAL: begin
          final_run <= 1'b0;
          idx       <= '0;
        end
        ael_pkg::A_SET_FINAL: begin
          final_run <= 1'b1;
          idx       <= '0;
        end
        ael_pkg::A_READ: begin
          if (!idx_last) begin
            idx <= idx + 1'b1;
          end
        end
        ael_pkg::A_STORE: begin
          if (label_full) begin
            overflow_flag <= 1'b1;
          end else begin
            label_count    <= label_count + 1'b1;
            running_length <= running_length + 8'd1;
          end
        end
        ael_pkg::A_FINISH: begin
          label_count <= '0;
          if (final_run) begin
            running_length <= 8'd1;
            overflow_flag  <= 1'b0;
          end else begin
            running_length <= running_length + 8'd1;
          end
        end
        default: ;
      endcase
    end
  end

  // Request latch, label buffer and output payload
  always_ff @(posedge clk) begin
    if (act == ael_pkg::A_LATCH && in_valid) begin
      char_q <= character;
      eos_q  <= end_of_string;
    end
    if (act == ael_pkg::A_STORE && !label_full) begin
      label_store[label_count[AW-1:0]] <= char_q;
    end
    if (act == ael_pkg::A_READ && !idx_last) begin
      rdata <= label_store[idx[AW-1:0]];
    end
    case (act)
      ael_pkg::A_PUT_LEN: begin
        out_byte     <= 8'(label_count);
        run_end      <= (label_count == '0);
        string_end   <= final_run && (label_count == '0);
        error        <= 1'b0;
        total_length <= (final_run && (label_count == '0)) ? running_length : 8'd0;
      end
      ael_pkg::A_PUT_DATA: begin
        out_byte     <= rdata;
        run_end      <= idx_last;
        string_end   <= final_run && idx_last;
        error        <= 1'b0;
        total_length <= (final_run && idx_last) ? running_length : 8'd0;
      end
      ael_pkg::A_PUT_ERR: begin
        out_byte     <= 8'd0;
        run_end      <= 1'b1;
        string_end   <= 1'b1;
        error        <= 1'b1;
        total_length <= 8'd0;
      end
      default: ;
    endcase
  end

endmodule
